// File: src/triangle_face_normal_top_assert.svh
// Assertion macros for the triangle face normal block.
// Used by triangle_face_normal_top; expects clk and rst in scope.
`ifndef TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define TFN_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define TFN_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: src/tfn_pkg.sv
// Package for the triangle face normal block: widths and pipeline types.
// No dependencies; used by every other file of the block except the assert header.
`default_nettype none
package tfn_pkg;
  localparam int CW = 16;               // coordinate width
  localparam int F = 14;                // fraction bits of the normal
  localparam int OW = 16;               // output field width
  localparam int DW = CW + 1;           // edge vector width
  localparam int PW = 2 * DW;           // partial product width
  localparam int NW = 2 * CW + 3;       // signed cross product width
  localparam int MAGW = 2 * CW + 2;     // cross product magnitude width
  localparam int SQW = 2 * MAGW;        // squared magnitude width
  localparam int SW = SQW + 2;          // squared length width
  localparam int AW = SW + 2 * F + 5;   // signed residual width
  localparam int RW = F + 1;            // root digit width
  localparam int XW = (RW + 1 > OW) ? RW + 1 : OW;

  typedef struct packed {
    logic [MAGW-1:0] mag;
    logic            neg;
  } comp_t;

  typedef struct packed {
    comp_t [2:0] c;
    logic        degen;
  } cross_t;

  typedef struct packed {
    logic [SW-1:0]          s;
    logic [2:0][AW-1:0]     d;
    logic [2:0][AW-1:0]     ms;
    logic [2:0][RW-1:0]     r;
    logic [2:0]             neg;
    logic                   degen;
  } stage_t;
endpackage
`default_nettype wire

// File: src/tfn_if.sv
// Valid/ready channel interfaces for vertex and normal items.
// Depends on tfn_pkg for the field widths.
`default_nettype none
interface tfn_vtx_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tfn_nrm_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::OW-1:0] nx, ny, nz;
  logic degenerate;
  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

// File: src/tfn_cross.sv
// Front end: input register, edge vectors, products and cross product.
// Depends on tfn_pkg and tfn_if.
`default_nettype none
module tfn_cross (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  tfn_vtx_if.sink         vtx,
  output logic            valid,
  output tfn_pkg::cross_t res
);
  import tfn_pkg::*;

  logic va, vb, vc;
  logic signed [CW-1:0] ra [3];
  logic signed [CW-1:0] rb [3];
  logic signed [CW-1:0] rc [3];
  logic signed [DW-1:0] p [3];
  logic signed [DW-1:0] q [3];
  logic signed [PW-1:0] pr [6];
  logic signed [NW-1:0] n [3];
  cross_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      va <= vtx.valid;
      vb <= va;
      vc <= vb;
      valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra[0] <= vtx.ax; ra[1] <= vtx.ay; ra[2] <= vtx.az;
      rb[0] <= vtx.bx; rb[1] <= vtx.by; rb[2] <= vtx.bz;
      rc[0] <= vtx.cx; rc[1] <= vtx.cy; rc[2] <= vtx.cz;
      for (int i = 0; i < 3; i++) begin
        p[i] <= DW'(rc[i]) - DW'(rb[i]);
        q[i] <= DW'(ra[i]) - DW'(rb[i]);
      end
      pr[0] <= p[1] * q[2];
      pr[1] <= p[2] * q[1];
      pr[2] <= p[2] * q[0];
      pr[3] <= p[0] * q[2];
      pr[4] <= p[0] * q[1];
      pr[5] <= p[1] * q[0];
      res <= res_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = NW'(pr[2*i]) - NW'(pr[2*i+1]);
      res_next.c[i].neg = n[i][NW-1];
      res_next.c[i].mag = n[i][NW-1] ? MAGW'(-n[i]) : MAGW'(n[i]);
    end
    res_next.degen = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end
endmodule
`default_nettype wire

// File: src/tfn_norm.sv
// Squares of the cross product, squared length and root search seeds.
// Depends on tfn_pkg.
`default_nettype none
module tfn_norm (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  tfn_pkg::cross_t cr,
  output logic            valid,
  output tfn_pkg::stage_t seed
);
  import tfn_pkg::*;

  logic ve;
  logic [SQW-1:0] sq [3];
  logic [2:0] neg_e;
  logic degen_e;
  logic [SW-1:0] ssum;
  stage_t seed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      ve <= in_valid;
      valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= cr.c[i].mag * cr.c[i].mag;
        neg_e[i] <= cr.c[i].neg;
      end
      degen_e <= cr.degen;
      seed <= seed_next;
    end
  end

  // Residual starts at x^2 * 2^(2F+2) - S with the trial odd number at minus one.
  always_comb begin
    ssum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    seed_next.s = ssum;
    for (int i = 0; i < 3; i++) begin
      seed_next.d[i] = (AW'(sq[i]) << (2 * F + 2)) - AW'(ssum);
      seed_next.ms[i] = AW'(0) - AW'(ssum);
      seed_next.r[i] = '0;
    end
    seed_next.neg = neg_e;
    seed_next.degen = degen_e;
  end
endmodule
`default_nettype wire

// File: src/tfn_root.sv
// Digit-serial pipeline that finds each rounded unit component, one bit per
// stage, and the output register. Depends on tfn_pkg and tfn_if.
`default_nettype none
module tfn_root (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  tfn_pkg::stage_t seed,
  tfn_nrm_if.source       nrm
);
  import tfn_pkg::*;

  stage_t stg [F+1];
  logic   sv  [F+1];

  for (genvar k = 0; k <= F; k++) begin : g_digit
    localparam int B = F - k;
    stage_t cur;
    stage_t nxt;
    logic   cur_v;

    if (k == 0) begin : g_first
      assign cur = seed;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur = stg[k-1];
      assign cur_v = sv[k-1];
    end

    // Trial of r | 2^B: accept when (m + 2^(B+1))^2 * S <= x^2 * 2^(2F+2).
    always_comb begin
      logic signed [AW-1:0] sx;
      logic signed [AW-1:0] trial;
      logic                 skip;
      logic                 acc;
      nxt = cur;
      sx = $signed(AW'(cur.s));
      for (int i = 0; i < 3; i++) begin
        trial = $signed(cur.d[i]) - (($signed(cur.ms[i]) <<< (B + 2)) + (sx <<< (2 * B + 2)));
        skip = (B < F) && cur.r[i][F];
        acc = !skip && !trial[AW-1];
        if (acc) begin
          nxt.d[i] = trial;
          nxt.ms[i] = $signed(cur.ms[i]) + (sx <<< (B + 1));
          nxt.r[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt;
      end
    end
  end

  logic signed [XW-1:0] mx [3];
  logic [OW-1:0] val [3];
  localparam logic [OW-1:0] ONE_OUT = OW'(1 << F);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = $signed(XW'(stg[F].r[i]));
      val[i] = stg[F].neg[i] ? OW'(-mx[i]) : OW'(mx[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm.valid <= 1'b0;
    end else if (en) begin
      nrm.valid <= sv[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (stg[F].degen) begin
        nrm.nx <= ONE_OUT;
        nrm.ny <= '0;
        nrm.nz <= '0;
      end else begin
        nrm.nx <= val[0];
        nrm.ny <= val[1];
        nrm.nz <= val[2];
      end
      nrm.degenerate <= stg[F].degen;
    end
  end
endmodule
`default_nettype wire

// File: src/triangle_face_normal_top.sv
// Top level of the triangle face normal block.
// Depends on tfn_pkg, tfn_if, tfn_cross, tfn_norm, tfn_root and the assert header.
//
//   Channel  Role   Payload
//   vtx      sink   ax ay az bx by bz cx cy cz (signed Q8.8)
//   nrm      source nx ny nz (signed Q1.14), degenerate
//
// One item enters per cycle when the pipeline can advance. Each item passes through
// four front stages (input, edges, products, cross), two length stages, the 15-stage
// digit search (one result bit per stage) and the output register.
// Reset (rst, synchronous) clears only the valid bits; the data registers are not reset.
// The whole pipeline moves together: it holds when the output item waits and
// nrm.ready is low, so no item is lost or repeated; otherwise it keeps filling.
`default_nettype none
module triangle_face_normal_top (
  input logic     clk,
  input logic     rst,
  tfn_vtx_if.sink   vtx,
  tfn_nrm_if.source nrm
);
  import tfn_pkg::*;

  `include "triangle_face_normal_top_assert.svh"

  logic   en;
  logic   cross_valid;
  cross_t cross_res;
  logic   seed_valid;
  stage_t seed;

  // The pipeline advances whenever the output register is empty or drained.
  assign en = !nrm.valid || nrm.ready;
  assign vtx.ready = en;

  // Edges and the exact integer cross product.
  tfn_cross u_cross (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .vtx   (vtx),
    .valid (cross_valid),
    .res   (cross_res)
  );

  // Squared length and starting residuals for the search.
  tfn_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cross_valid),
    .cr       (cross_res),
    .valid    (seed_valid),
    .seed     (seed)
  );

  // Bit-by-bit rounded component search and output register.
  tfn_root u_root (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (seed_valid),
    .seed     (seed),
    .nrm      (nrm)
  );

  // A degenerate triangle always yields the x axis.
  `TFN_ASSERT_NOW(a_degen_axis, nrm.valid && nrm.degenerate, (nrm.ny == '0) && (nrm.nz == '0), "degenerate item with nonzero y or z")

  // A proper triangle never yields an all-zero normal.
  `TFN_ASSERT_NOW(a_nonzero, nrm.valid && !nrm.degenerate, (nrm.nx != '0) || (nrm.ny != '0) || (nrm.nz != '0), "zero normal on a proper triangle")

  // A waiting result blocks new input items.
  `TFN_ASSERT_NOW(a_stall_blocks, nrm.valid && !nrm.ready, !vtx.ready, "input accepted while output stalled")

  // The degenerate flag of a stalled result must not change in the next cycle.
  `TFN_ASSERT_NEXT(a_hold_degen, nrm.valid && !nrm.ready, $stable(nrm.degenerate), "degenerate flag changed during stall")
endmodule
`default_nettype wire
